@@ design/lcdn_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, codes and constants of the character LCD 4-bit write sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // widths of the channel fields
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int ROW_W   = 2;
    localparam int NIB_W   = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    // request codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CGRAM  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 8'd1;

    // configuration reset values
    localparam logic [CFG_DAT_W-1:0] ENABLE_TICKS_RST = 8'd1;
    localparam logic [CFG_DAT_W-1:0] SETTLE_TICKS_RST = 8'd5;

    // display addressing
    localparam logic [BYTE_W-1:0] DDRAM_ROW0  = 8'h80;
    localparam logic [BYTE_W-1:0] DDRAM_ROW1  = 8'hC0;
    localparam logic [BYTE_W-1:0] CGRAM_BASE  = 8'h40;
    localparam logic [ROW_W-1:0]  ROW_SECOND  = 2'd1;
    localparam logic [BYTE_W-1:0] CGRAM_SLOTS = 8'd8;

    // power-up command sequence
    localparam int INIT_LEN = 7;
    localparam int STEP_W   = 3;
    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_LEN - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI1,
        PH_GAP,
        PH_HI2,
        PH_SETTLE
    } phase_t;

    typedef struct packed {
        logic [CFG_DAT_W-1:0] enable_ticks;
        logic [CFG_DAT_W-1:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic             pin_rs;
        logic             pin_rw;
        logic             pin_en;
        logic [NIB_W-1:0] pin_data;
        logic             busy_res;
        logic             accepted;
    } rsp_t;

    function automatic logic [BYTE_W-1:0] init_byte(input logic [STEP_W-1:0] step);
        logic [BYTE_W-1:0] b;
        case (step)
            3'd0:    b = 8'h33;
            3'd1:    b = 8'h32;
            3'd2:    b = 8'h28;
            3'd3:    b = 8'h01;
            3'd4:    b = 8'h02;
            3'd5:    b = 8'h0C;
            3'd6:    b = 8'h06;
            default: b = 8'h06;
        endcase
        return b;
    endfunction

endpackage

@@ design/lcdn_if.sv @@
// ----------------------------------------------------------------------------
// lcdn interfaces
// Request, response and configuration channels of the LCD write sequencer.
// ----------------------------------------------------------------------------
interface lcdn_req_if;
    logic                       valid;
    logic                       ready;
    logic [lcdn_pkg::CMD_W-1:0] cmd;
    logic [lcdn_pkg::BYTE_W-1:0] value;
    logic [lcdn_pkg::ROW_W-1:0] row;

    modport source (output valid, output cmd, output value, output row, input ready);
    modport sink   (input valid, input cmd, input value, input row, output ready);
endinterface

interface lcdn_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        pin_rs;
    logic                        pin_rw;
    logic                        pin_en;
    logic [lcdn_pkg::NIB_W-1:0]  pin_data;
    logic                        busy_res;
    logic                        accepted;

    modport source (output valid, output pin_rs, output pin_rw, output pin_en,
                    output pin_data, output busy_res, output accepted, input ready);
    modport sink   (input valid, input pin_rs, input pin_rw, input pin_en,
                    input pin_data, input busy_res, input accepted, output ready);
endinterface

interface lcdn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcdn_pkg::CFG_IDX_W-1:0]  index;
    logic [lcdn_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/char_lcd_nibble_write_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_unit
// Character LCD write sequencer for a 4-bit HD44780 style bus.
// ----------------------------------------------------------------------------
// Usage:
//   req : one word per bus tick; cmd selects tick, command byte, data byte,
//         locate, initialize or CGRAM slot select, with value and row.
//   rsp : one word per request word, carrying the LCD pins for that tick,
//         busy_res and accepted (set when the request started a byte).
//   cfg : register writes, index 0 enable_ticks, index 1 settle_ticks;
//         always ready, other indexes are dropped. Write only while idle.
// Output: the response word is registered and appears in the cycle after its request word.
// Throughput: one request word per cycle while req is ready; the state update
//   is a single pass of logic from the state registers to the result register.
// Reset: sequencer idle, no response pending, enable_ticks 1, settle_ticks 5.
// Stall: when rsp is not taken the result register holds its word and req
//   ready drops; a request is taken again in the cycle that rsp drains.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_unit (
    input  logic         clk,
    input  logic         rst_n,
    lcdn_req_if.sink     req,
    lcdn_rsp_if.source   rsp,
    lcdn_cfg_if.sink     cfg
);
    import lcdn_pkg::*;

    cfg_t cfg_val;
    rsp_t core_rsp;
    rsp_t out_rsp;
    logic space;
    logic step;

    // configuration registers
    lcdn_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .wr_ready (cfg.ready),
        .cfg      (cfg_val)
    );

    // request accepted when the result register has room
    assign req.ready = space;
    assign step      = req.valid && space;

    lcdn_seq_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (req.cmd),
        .value (req.value),
        .row   (req.row),
        .cfg   (cfg_val),
        .rsp   (core_rsp)
    );

    lcdn_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step),
        .rsp_in  (core_rsp),
        .take    (rsp.ready),
        .space   (space),
        .valid   (rsp.valid),
        .rsp_out (out_rsp)
    );

    // response pins
    assign rsp.pin_rs   = out_rsp.pin_rs;
    assign rsp.pin_rw   = out_rsp.pin_rw;
    assign rsp.pin_en   = out_rsp.pin_en;
    assign rsp.pin_data = out_rsp.pin_data;
    assign rsp.busy_res = out_rsp.busy_res;
    assign rsp.accepted = out_rsp.accepted;

endmodule

@@ design/lcdn_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lcdn_cfg_regs
// Enable and settle tick registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module lcdn_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    input  logic [lcdn_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [lcdn_pkg::CFG_DAT_W-1:0] wr_data,
    output logic                           wr_ready,
    output lcdn_pkg::cfg_t                 cfg
);
    import lcdn_pkg::*;

    cfg_t cfg_reg;

    // writes are always taken
    assign wr_ready = 1'b1;

    // register file, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_ticks <= ENABLE_TICKS_RST;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
        end
        else if (wr_valid)
        begin
            if (wr_index == REG_ENABLE_TICKS)
                cfg_reg.enable_ticks <= wr_data;
            if (wr_index == REG_SETTLE_TICKS)
                cfg_reg.settle_ticks <= wr_data;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/lcdn_seq_core.sv @@
// ----------------------------------------------------------------------------
// lcdn_seq_core
// Byte sequencer: request decode, nibble phases, init sequence, pin values.
// ----------------------------------------------------------------------------
module lcdn_seq_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [lcdn_pkg::CMD_W-1:0]      cmd,
    input  logic [lcdn_pkg::BYTE_W-1:0]     value,
    input  logic [lcdn_pkg::ROW_W-1:0]      row,
    input  lcdn_pkg::cfg_t                  cfg,
    output lcdn_pkg::rsp_t                  rsp
);
    import lcdn_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [BYTE_W-1:0]   timer_reg,  timer_next;
    logic [BYTE_W-1:0]   byte_reg,   byte_next;
    logic                sel_reg,    sel_next;
    logic [STEP_W-1:0]   istep_reg,  istep_next;
    logic                iact_reg,   iact_next;

    logic [BYTE_W-1:0]   en_len;

    // zero enable length counts as one tick
    assign en_len = (cfg.enable_ticks == '0) ? BYTE_W'(1) : cfg.enable_ticks;

    // state registers, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            byte_reg  <= '0;
            sel_reg   <= 1'b0;
            istep_reg <= '0;
            iact_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            byte_reg  <= byte_next;
            sel_reg   <= sel_next;
            istep_reg <= istep_next;
            iact_reg  <= iact_next;
        end
    end

    // next state and pin values
    always_comb
    begin
        phase_t            ph;
        logic [BYTE_W-1:0] tmr;
        logic [BYTE_W-1:0] tmr_dec;
        logic              finish;
        logic [STEP_W-1:0] st_inc;

        ph         = phase_reg;
        tmr        = timer_reg;
        byte_next  = byte_reg;
        sel_next   = sel_reg;
        istep_next = istep_reg;
        iact_next  = iact_reg;
        rsp        = '0;
        finish     = 1'b0;

        // request decode while idle
        if (phase_reg == PH_IDLE)
        begin
            case (cmd)
                CMD_BYTE:
                begin
                    byte_next = value;
                    sel_next  = 1'b0;
                    rsp.accepted = 1'b1;
                end
                CMD_DATA:
                begin
                    byte_next = value;
                    sel_next  = 1'b1;
                    rsp.accepted = 1'b1;
                end
                CMD_LOCATE:
                begin
                    byte_next = ((row == ROW_SECOND) ? DDRAM_ROW1 : DDRAM_ROW0) + value;
                    sel_next  = 1'b0;
                    rsp.accepted = 1'b1;
                end
                CMD_INIT:
                begin
                    iact_next  = 1'b1;
                    istep_next = '0;
                    byte_next  = init_byte('0);
                    sel_next   = 1'b0;
                    rsp.accepted = 1'b1;
                end
                CMD_CGRAM:
                begin
                    if (value < CGRAM_SLOTS)
                    begin
                        byte_next = CGRAM_BASE + {value[4:0], 3'b000};
                        sel_next  = 1'b0;
                        rsp.accepted = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (rsp.accepted)
            begin
                ph  = PH_HI1;
                tmr = en_len;
            end
        end

        phase_next = ph;
        timer_next = tmr;
        tmr_dec    = tmr - BYTE_W'(1);
        st_inc     = istep_next + STEP_W'(1);

        // pins for this tick and phase advance
        if (ph != PH_IDLE)
        begin
            rsp.busy_res = 1'b1;
            rsp.pin_rs   = sel_next;
            rsp.pin_en   = (ph == PH_HI1) || (ph == PH_HI2);
            rsp.pin_data = (ph == PH_HI1) ? byte_next[7:4] : byte_next[3:0];
            case (ph)
                PH_HI1:
                begin
                    timer_next = tmr_dec;
                    if (tmr_dec == '0)
                        phase_next = PH_GAP;
                end
                PH_GAP:
                begin
                    phase_next = PH_HI2;
                    timer_next = en_len;
                end
                PH_HI2:
                begin
                    timer_next = tmr_dec;
                    if (tmr_dec == '0)
                    begin
                        if (cfg.settle_ticks != '0)
                        begin
                            phase_next = PH_SETTLE;
                            timer_next = cfg.settle_ticks;
                        end
                        else
                            finish = 1'b1;
                    end
                end
                default:
                begin
                    timer_next = tmr_dec;
                    if (tmr_dec == '0)
                        finish = 1'b1;
                end
            endcase
        end

        // end of byte: next init command or back to idle
        if (finish)
        begin
            if (iact_next && (istep_next < INIT_LAST))
            begin
                istep_next = st_inc;
                byte_next  = init_byte(st_inc);
                sel_next   = 1'b0;
                phase_next = PH_HI1;
                timer_next = en_len;
            end
            else
            begin
                iact_next  = 1'b0;
                istep_next = '0;
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("timer not cleared in idle");
    a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
        iact_reg |-> (phase_reg != PH_IDLE))
        else $error("init sequence active while idle");
    a_init_cmd_select: assert property (@(posedge clk) disable iff (!rst_n)
        iact_reg |-> (!sel_reg && (istep_reg <= INIT_LAST)))
        else $error("init sequence state out of range");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.accepted |-> (rsp.busy_res && rsp.pin_en && (phase_reg == PH_IDLE)))
        else $error("accepted request not driving first enable tick");
`endif

endmodule

@@ design/lcdn_out_reg.sv @@
// ----------------------------------------------------------------------------
// lcdn_out_reg
// Result register between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module lcdn_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  lcdn_pkg::rsp_t rsp_in,
    input  logic           take,
    output logic           space,
    output logic           valid,
    output lcdn_pkg::rsp_t rsp_out
);
    import lcdn_pkg::*;

    logic valid_reg;
    rsp_t data_reg;

    // free when empty or being drained this cycle
    assign space = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= rsp_in;
    end

    assign valid   = valid_reg;
    assign rsp_out = data_reg;

endmodule
